FILE: rtl/smf_track_event_parser_assert.svh
// Assertion helpers for the track event parser
`ifndef SMF_TRACK_EVENT_PARSER_ASSERT_SVH
`define SMF_TRACK_EVENT_PARSER_ASSERT_SVH

// same-cycle implication
`define SMF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smf assertion failed");

// next-cycle implication
`define SMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smf assertion failed");

`endif

FILE: rtl/smf_pkg.sv
package smf_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE           = 3'd0,
    ERR_TRUNCATED      = 3'd1,
    ERR_OVERLONG       = 3'd2,
    ERR_NO_RUNNING     = 3'd3,
    ERR_INVALID_STATUS = 3'd4
  } err_e;

  localparam logic [7:0] STATUS_META      = 8'hFF;
  localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;
  localparam logic [3:0] NIBBLE_SYSTEM    = 4'hF;
  localparam logic [3:0] NIBBLE_PROGRAM   = 4'hC;
  localparam logic [3:0] NIBBLE_PRESSURE  = 4'hD;

  localparam int unsigned VLQ_MAX     = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  // one accepted byte: an optional event/payload result, then an optional end or error result
  typedef struct packed {
    logic        has_first;
    kind_e       first_kind;
    logic [7:0]  status;
    logic [7:0]  meta;
    logic [27:0] length;
    logic [7:0]  param_first;
    logic [7:0]  param_second;
    logic [7:0]  payload;
    logic        last;
    logic        has_tail;
    kind_e       tail_kind;
    err_e        err;
    logic [31:0] tick;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] abs_tick;
    logic [7:0]  event_status;
    logic [7:0]  meta_kind;
    logic [27:0] payload_length;
    logic [7:0]  param_first;
    logic [7:0]  param_second;
    logic [7:0]  payload_byte;
    logic        event_last;
    logic [2:0]  error_code;
  } result_t;

  // program change and channel pressure carry one data byte
  function automatic logic one_data_byte(input logic [7:0] status);
    return (status[7:4] == NIBBLE_PROGRAM) || (status[7:4] == NIBBLE_PRESSURE);
  endfunction

endpackage

FILE: rtl/smf_in_if.sv
interface smf_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] chunk_byte;

  modport source (output valid, output cmd, output chunk_byte, input ready);
  modport sink (input valid, input cmd, input chunk_byte, output ready);
endinterface

FILE: rtl/smf_cfg_if.sv
interface smf_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] track_length;

  modport source (output valid, output track_length, input ready);
  modport sink (input valid, input track_length, output ready);
endinterface

FILE: rtl/smf_out_if.sv
interface smf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] abs_tick;
  logic [7:0]  event_status;
  logic [7:0]  meta_kind;
  logic [27:0] payload_length;
  logic [7:0]  param_first;
  logic [7:0]  param_second;
  logic [7:0]  payload_byte;
  logic        event_last;
  logic [2:0]  error_code;

  modport source (
    output valid, output kind, output abs_tick, output event_status, output meta_kind,
    output payload_length, output param_first, output param_second, output payload_byte,
    output event_last, output error_code, input ready
  );
  modport sink (
    input valid, input kind, input abs_tick, input event_status, input meta_kind,
    input payload_length, input param_first, input param_second, input payload_byte,
    input event_last, input error_code, output ready
  );
endinterface

FILE: rtl/smf_front.sv
module smf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            in_cmd_i,
  input  logic [7:0]      in_byte_i,
  input  logic            full_i,
  output logic            push_o,
  output smf_pkg::entry_t entry_o
);
  import smf_pkg::*;

  localparam logic [2:0] PH_DELTA    = 3'd0;
  localparam logic [2:0] PH_STATUS   = 3'd1;
  localparam logic [2:0] PH_METATYPE = 3'd2;
  localparam logic [2:0] PH_LEN      = 3'd3;
  localparam logic [2:0] PH_PARAM1   = 3'd4;
  localparam logic [2:0] PH_PARAM2   = 3'd5;
  localparam logic [2:0] PH_PAYLOAD  = 3'd6;

  logic [2:0]  phase_q, phase_d;
  logic [27:0] vlq_q, vlq_d;
  logic [2:0]  vlq_cnt_q, vlq_cnt_d;
  logic [31:0] tick_q, tick_d;
  logic [7:0]  run_q, run_d;
  logic [7:0]  cur_q, cur_d;
  logic [7:0]  meta_q, meta_d;
  logic [27:0] left_q, left_d;
  logic [31:0] taken_q, taken_d;
  logic [7:0]  held_q, held_d;
  logic        fin_q, fin_d;
  logic [31:0] tl_q, tl_d;
  logic [31:0] rem_q, rem_d;   // bytes still in the chunk before the next byte

  logic        accept;
  logic [27:0] vlq_new;
  logic        overlong;
  logic        last_byte;
  logic        done;
  logic        end_ev;
  logic        fail;
  err_e        fail_code;
  logic [7:0]  st;
  logic        running;
  logic [32:0] rem_diff;
  entry_t      ent;

  assign accept     = in_valid_i && !full_i;
  assign in_ready_o = !full_i;
  assign vlq_new    = {vlq_q[20:0], in_byte_i[6:0]};
  assign overlong   = in_byte_i[7] && (vlq_cnt_q == 3'(VLQ_MAX - 1));
  assign last_byte  = rem_q <= 32'd1;
  assign running    = !in_byte_i[7];
  assign st         = running ? run_q : in_byte_i;

  always_comb begin
    phase_d   = phase_q;
    vlq_d     = vlq_q;
    vlq_cnt_d = vlq_cnt_q;
    tick_d    = tick_q;
    run_d     = run_q;
    cur_d     = cur_q;
    meta_d    = meta_q;
    left_d    = left_q;
    taken_d   = taken_q;
    held_d    = held_q;
    fin_d     = fin_q;
    tl_d      = tl_q;
    done      = 1'b0;
    end_ev    = 1'b0;
    fail      = 1'b0;
    fail_code = ERR_NONE;
    ent            = '0;
    ent.first_kind = KIND_HEADER;
    ent.tail_kind  = KIND_END;
    ent.err        = ERR_NONE;

    if (cfg_valid_i) begin
      tl_d = cfg_data_i;
    end

    if (accept) begin
      if (in_cmd_i) begin
        phase_d   = PH_DELTA;
        vlq_d     = '0;
        vlq_cnt_d = '0;
        tick_d    = '0;
        run_d     = '0;
        cur_d     = '0;
        meta_d    = '0;
        left_d    = '0;
        taken_d   = '0;
        held_d    = '0;
        fin_d     = (tl_q == '0);
        ent.has_tail = (tl_q == '0);
      end else if (!fin_q) begin
        taken_d = taken_q + 32'd1;
        unique case (phase_q)
          PH_DELTA: begin
            vlq_d     = vlq_new;
            vlq_cnt_d = vlq_cnt_q + 3'd1;
            if (overlong) begin
              fail = 1'b1; fail_code = ERR_OVERLONG; done = 1'b1;
            end else if (!in_byte_i[7]) begin
              tick_d    = tick_q + {4'd0, vlq_new};
              vlq_d     = '0;
              vlq_cnt_d = '0;
              phase_d   = PH_STATUS;
            end
          end
          PH_STATUS: begin
            if (!running) begin
              run_d = (in_byte_i[7:4] != NIBBLE_SYSTEM) ? in_byte_i : 8'd0;
            end
            if (running && run_q == 8'd0) begin
              fail = 1'b1; fail_code = ERR_NO_RUNNING; done = 1'b1;
            end else begin
              cur_d  = st;
              meta_d = '0;
              if (st == STATUS_META) begin
                phase_d = PH_METATYPE;
              end else if (st == STATUS_SYSEX || st == STATUS_SYSEX_ESC) begin
                vlq_d     = '0;
                vlq_cnt_d = '0;
                phase_d   = PH_LEN;
              end else if (st[7:4] == NIBBLE_SYSTEM) begin
                fail = 1'b1; fail_code = ERR_INVALID_STATUS; done = 1'b1;
              end else if (!running) begin
                if (one_data_byte(st) ? last_byte : (rem_q <= 32'd2)) begin
                  fail = 1'b1; fail_code = ERR_TRUNCATED; done = 1'b1;
                end else begin
                  phase_d = PH_PARAM1;
                end
              end else if (!one_data_byte(st) && last_byte) begin
                fail = 1'b1; fail_code = ERR_TRUNCATED; done = 1'b1;
              end else begin
                held_d = in_byte_i;
                if (one_data_byte(st)) begin
                  ent.has_first   = 1'b1;
                  ent.status      = st;
                  ent.length      = 28'd1;
                  ent.param_first = in_byte_i;
                  ent.last        = 1'b1;
                  end_ev          = 1'b1;
                  done            = 1'b1;
                end else begin
                  phase_d = PH_PARAM2;
                end
              end
            end
          end
          PH_METATYPE: begin
            meta_d    = in_byte_i;
            vlq_d     = '0;
            vlq_cnt_d = '0;
            phase_d   = PH_LEN;
          end
          PH_LEN: begin
            vlq_d     = vlq_new;
            vlq_cnt_d = vlq_cnt_q + 3'd1;
            if (overlong) begin
              fail = 1'b1; fail_code = ERR_OVERLONG; done = 1'b1;
            end else if (!in_byte_i[7]) begin
              vlq_d     = '0;
              vlq_cnt_d = '0;
              // declared length beyond what follows this byte
              if ((vlq_new != '0) && ({4'd0, vlq_new} >= rem_q)) begin
                fail = 1'b1; fail_code = ERR_TRUNCATED; done = 1'b1;
              end else begin
                ent.has_first = 1'b1;
                ent.status    = cur_q;
                ent.meta      = (cur_q == STATUS_META) ? meta_q : 8'd0;
                ent.length    = vlq_new;
                ent.last      = (vlq_new == '0);
                if (vlq_new == '0) begin
                  end_ev = 1'b1;
                  done   = 1'b1;
                end else begin
                  left_d  = vlq_new;
                  phase_d = PH_PAYLOAD;
                end
              end
            end
          end
          PH_PARAM1: begin
            held_d = in_byte_i;
            if (one_data_byte(cur_q)) begin
              ent.has_first   = 1'b1;
              ent.status      = cur_q;
              ent.length      = 28'd1;
              ent.param_first = in_byte_i;
              ent.last        = 1'b1;
              end_ev          = 1'b1;
              done            = 1'b1;
            end else begin
              phase_d = PH_PARAM2;
            end
          end
          PH_PARAM2: begin
            ent.has_first    = 1'b1;
            ent.status       = cur_q;
            ent.length       = 28'd2;
            ent.param_first  = held_q;
            ent.param_second = in_byte_i;
            ent.last         = 1'b1;
            end_ev           = 1'b1;
            done             = 1'b1;
          end
          PH_PAYLOAD: begin
            left_d         = left_q - 28'd1;
            ent.has_first  = 1'b1;
            ent.first_kind = KIND_PAYLOAD;
            ent.status     = cur_q;
            ent.meta       = (cur_q == STATUS_META) ? meta_q : 8'd0;
            ent.payload    = in_byte_i;
            ent.last       = (left_d == '0);
            if (left_d == '0) begin
              end_ev = 1'b1;
              done   = 1'b1;
            end
          end
          default: begin
            phase_d = PH_DELTA;
          end
        endcase

        if (!done && last_byte) begin
          fail      = 1'b1;
          fail_code = ERR_TRUNCATED;
        end
        if (end_ev) begin
          phase_d   = PH_DELTA;
          vlq_d     = '0;
          vlq_cnt_d = '0;
          if (last_byte) begin
            fin_d         = 1'b1;
            ent.has_tail  = 1'b1;
            ent.tail_kind = KIND_END;
          end
        end
        if (fail) begin
          fin_d         = 1'b1;
          ent.has_tail  = 1'b1;
          ent.tail_kind = KIND_ERROR;
          ent.err       = fail_code;
        end
      end
    end

    ent.tick = tick_d;
  end

  // remaining count kept registered so the per-byte checks are plain compares
  assign rem_diff = {1'b0, tl_d} - {1'b0, taken_d};
  assign rem_d    = rem_diff[32] ? 32'd0 : rem_diff[31:0];

  assign push_o  = accept && (ent.has_first || ent.has_tail);
  assign entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_DELTA;
      vlq_q     <= '0;
      vlq_cnt_q <= '0;
      tick_q    <= '0;
      run_q     <= '0;
      cur_q     <= '0;
      meta_q    <= '0;
      left_q    <= '0;
      taken_q   <= '0;
      held_q    <= '0;
      fin_q     <= 1'b1;
      tl_q      <= '0;
      rem_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      vlq_q     <= vlq_d;
      vlq_cnt_q <= vlq_cnt_d;
      tick_q    <= tick_d;
      run_q     <= run_d;
      cur_q     <= cur_d;
      meta_q    <= meta_d;
      left_q    <= left_d;
      taken_q   <= taken_d;
      held_q    <= held_d;
      fin_q     <= fin_d;
      tl_q      <= tl_d;
      rem_q     <= rem_d;
    end
  end

endmodule

FILE: rtl/smf_queue.sv
module smf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  smf_pkg::entry_t entry_i,
  input  logic            pop_i,
  output smf_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);
  import smf_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d;
  logic [PTR_W-1:0]   rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign head_o  = slots_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/smf_back.sv
module smf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  smf_pkg::entry_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output smf_pkg::result_t result_o
);
  import smf_pkg::*;

  logic    sub_q, sub_d;   // first result of the head entry already transferred
  logic    tail_now;
  logic    fire;
  result_t res;

  assign tail_now    = sub_q || !head_i.has_first;
  assign out_valid_o = !empty_i;
  assign fire        = out_valid_o && out_ready_i;
  assign pop_o       = fire && (tail_now || !head_i.has_tail);

  always_comb begin
    res          = '0;
    res.abs_tick = head_i.tick;
    if (tail_now) begin
      res.kind       = head_i.tail_kind;
      res.error_code = head_i.err;
    end else begin
      res.kind           = head_i.first_kind;
      res.event_status   = head_i.status;
      res.meta_kind      = head_i.meta;
      res.payload_length = head_i.length;
      res.param_first    = head_i.param_first;
      res.param_second   = head_i.param_second;
      res.payload_byte   = head_i.payload;
      res.event_last     = head_i.last;
    end
  end

  assign result_o = res;

  always_comb begin
    sub_d = sub_q;
    if (fire) begin
      sub_d = !pop_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule

FILE: rtl/smf_track_event_parser.sv
// A result is registered in the result queue and presented from its head once earlier results are out.
// Throughput: one byte per cycle while the result queue is not full; the byte parser settles each byte combinationally.
// A byte with two results (result plus track end or error) presents them in turn from one queue entry; the
// four-entry result queue absorbs this until it fills and input ready drops.
// Reset: queue empty, track length 0, track finished; bytes are ignored until a restart.
`include "smf_track_event_parser_assert.svh"

module smf_track_event_parser (
  input logic       clk_i,
  input logic       rst_ni,
  smf_in_if.sink    in_i,
  smf_cfg_if.sink   cfg_i,
  smf_out_if.source out_o
);
  import smf_pkg::*;

  logic    push;
  logic    pop;
  logic    empty;
  logic    full;
  entry_t  push_entry;
  entry_t  head;
  result_t res;

  assign cfg_i.ready = 1'b1;

  smf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.track_length),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_cmd_i    (in_i.cmd),
    .in_byte_i   (in_i.chunk_byte),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  smf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  smf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (res)
  );

  assign out_o.kind           = res.kind;
  assign out_o.abs_tick       = res.abs_tick;
  assign out_o.event_status   = res.event_status;
  assign out_o.meta_kind      = res.meta_kind;
  assign out_o.payload_length = res.payload_length;
  assign out_o.param_first    = res.param_first;
  assign out_o.param_second   = res.param_second;
  assign out_o.payload_byte   = res.payload_byte;
  assign out_o.event_last     = res.event_last;
  assign out_o.error_code     = res.error_code;

  `SMF_ASSERT_IMPL(a_error_has_code, clk_i, rst_ni, out_o.valid && out_o.kind == KIND_ERROR, out_o.error_code != ERR_NONE)
  `SMF_ASSERT_IMPL(a_code_only_on_error, clk_i, rst_ni, out_o.valid && out_o.kind != KIND_ERROR, out_o.error_code == ERR_NONE)
  `SMF_ASSERT_IMPL(a_end_not_last, clk_i, rst_ni, out_o.valid && (out_o.kind == KIND_END || out_o.kind == KIND_ERROR), !out_o.event_last)
  `SMF_ASSERT_IMPL(a_stall_means_pending, clk_i, rst_ni, !in_i.ready, out_o.valid)
  `SMF_ASSERT_NEXT(a_held_result_stays, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.abs_tick))

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import smf_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned ITEMS_PER_REGIME = 650;
  localparam logic [27:0] VLQ_TOP = 28'h0FFF_FFFF;

  typedef enum bit [2:0] {
    P_DELTA,
    P_STATUS,
    P_META_TYPE,
    P_LENGTH,
    P_DATA1,
    P_DATA2,
    P_PAYLOAD
  } parse_phase_e;

  // Tracks the parser byte by byte and holds the results it must emit, oldest first.
  class track_scoreboard;
    result_t      expected_q[$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  n_header, n_payload, n_end, n_error;
    bit [31:0]    trk_len;
    parse_phase_e ph;
    bit [27:0]    vlq;
    bit [2:0]     vcnt;
    bit [31:0]    tick;
    bit [7:0]     run_st, cur_st, cur_meta, held;
    bit [27:0]    left;
    bit [31:0]    taken;
    bit           done;

    function new();
      trk_len = 0;
      clear_cursor();
      done = 1'b1;
    endfunction

    function void clear_cursor();
      ph = P_DELTA;
      vlq = '0;
      vcnt = '0;
      tick = '0;
      run_st = '0;
      cur_st = '0;
      cur_meta = '0;
      held = '0;
      left = '0;
      taken = '0;
    endfunction

    function void set_length(bit [31:0] v);
      trk_len = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push(kind_e k, bit [7:0] st, bit [7:0] meta, bit [27:0] len,
                       bit [7:0] p1, bit [7:0] p2, bit [7:0] pb, bit last, err_e err);
      result_t r;
      r.kind = k;
      r.abs_tick = tick;
      r.event_status = st;
      r.meta_kind = meta;
      r.payload_length = len;
      r.param_first = p1;
      r.param_second = p2;
      r.payload_byte = pb;
      r.event_last = last;
      r.error_code = err;
      expected_q.push_back(r);
    endfunction

    function void fail_track(err_e code);
      done = 1'b1;
      push(KIND_ERROR, 0, 0, 0, 0, 0, 0, 1'b0, code);
    endfunction

    function void close_event();
      ph = P_DELTA;
      vlq = '0;
      vcnt = '0;
      if (taken >= trk_len) begin
        done = 1'b1;
        push(KIND_END, 0, 0, 0, 0, 0, 0, 1'b0, ERR_NONE);
      end
    endfunction

    // 1: value complete, 0: more bytes follow, -1: continuation on the last allowed byte
    function int vlq_step(bit [7:0] b);
      vlq = {vlq[20:0], b[6:0]};
      vcnt++;
      if (!b[7]) return 1;
      if (vcnt >= VLQ_MAX) return -1;
      return 0;
    endfunction

    function bit [7:0] meta_of();
      return (cur_st == STATUS_META) ? cur_meta : 8'h00;
    endfunction

    function bit [1:0] data_count(bit [7:0] st);
      return (st[7:4] == NIBBLE_PROGRAM || st[7:4] == NIBBLE_PRESSURE) ? 2'd1 : 2'd2;
    endfunction

    function void note_input(bit restart, bit [7:0] b);
      bit [31:0] rem;
      bit [27:0] l;
      bit [7:0]  st;
      bit [1:0]  n;
      bit        running;
      int        r;
      if (restart) begin
        clear_cursor();
        done = 1'b0;
        if (trk_len == 0) begin
          done = 1'b1;
          push(KIND_END, 0, 0, 0, 0, 0, 0, 1'b0, ERR_NONE);
        end
        return;
      end
      if (done) return;
      taken++;
      rem = (taken < trk_len) ? trk_len - taken : 32'd0;
      case (ph)
        P_DELTA: begin
          r = vlq_step(b);
          if (r < 0) begin
            fail_track(ERR_OVERLONG);
            return;
          end
          if (r > 0) begin
            tick += vlq;
            vlq = '0;
            vcnt = '0;
            ph = P_STATUS;
          end
        end
        P_STATUS: begin
          running = !b[7];
          if (!running) begin
            st = b;
            run_st = (b < 8'hF0) ? b : 8'h00;
          end else begin
            st = run_st;
            if (st == 8'h00) begin
              fail_track(ERR_NO_RUNNING);
              return;
            end
          end
          cur_st = st;
          cur_meta = '0;
          if (st == STATUS_META) begin
            ph = P_META_TYPE;
          end else if (st == STATUS_SYSEX || st == STATUS_SYSEX_ESC) begin
            vlq = '0;
            vcnt = '0;
            ph = P_LENGTH;
          end else if (st[7:4] == NIBBLE_SYSTEM) begin
            fail_track(ERR_INVALID_STATUS);
            return;
          end else begin
            n = data_count(st);
            if (!running) begin
              if (rem < n) begin
                fail_track(ERR_TRUNCATED);
                return;
              end
              ph = P_DATA1;
            end else begin
              // the byte just taken is already the first data byte
              if (rem < n - 1) begin
                fail_track(ERR_TRUNCATED);
                return;
              end
              held = b;
              if (n == 1) begin
                push(KIND_HEADER, st, 0, 28'd1, b, 0, 0, 1'b1, ERR_NONE);
                close_event();
                return;
              end
              ph = P_DATA2;
            end
          end
        end
        P_META_TYPE: begin
          cur_meta = b;
          vlq = '0;
          vcnt = '0;
          ph = P_LENGTH;
        end
        P_LENGTH: begin
          r = vlq_step(b);
          if (r < 0) begin
            fail_track(ERR_OVERLONG);
            return;
          end
          if (r > 0) begin
            l = vlq;
            vlq = '0;
            vcnt = '0;
            if ({4'b0, l} > rem) begin
              fail_track(ERR_TRUNCATED);
              return;
            end
            push(KIND_HEADER, cur_st, meta_of(), l, 0, 0, 0, l == 0, ERR_NONE);
            if (l == 0) begin
              close_event();
              return;
            end
            left = l;
            ph = P_PAYLOAD;
          end
        end
        P_DATA1: begin
          held = b;
          if (data_count(cur_st) == 1) begin
            push(KIND_HEADER, cur_st, 0, 28'd1, b, 0, 0, 1'b1, ERR_NONE);
            close_event();
            return;
          end
          ph = P_DATA2;
        end
        P_DATA2: begin
          push(KIND_HEADER, cur_st, 0, 28'd2, held, b, 0, 1'b1, ERR_NONE);
          close_event();
          return;
        end
        P_PAYLOAD: begin
          left = left - 1;
          push(KIND_PAYLOAD, cur_st, meta_of(), 0, 0, 0, b, left == 0, ERR_NONE);
          if (left == 0) begin
            close_event();
            return;
          end
        end
        default: ph = P_DELTA;
      endcase
      if (!done && taken >= trk_len) fail_track(ERR_TRUNCATED);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d tick %0h", got.kind, got.abs_tick);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      case (want.kind)
        KIND_HEADER:  n_header++;
        KIND_PAYLOAD: n_payload++;
        KIND_END:     n_end++;
        default:      n_error++;
      endcase
      cmp("kind", want.kind, got.kind);
      cmp("abs_tick", want.abs_tick, got.abs_tick);
      cmp("event_status", want.event_status, got.event_status);
      cmp("meta_kind", want.meta_kind, got.meta_kind);
      cmp("payload_length", want.payload_length, got.payload_length);
      cmp("param_first", want.param_first, got.param_first);
      cmp("param_second", want.param_second, got.param_second);
      cmp("payload_byte", want.payload_byte, got.payload_byte);
      cmp("event_last", want.event_last, got.event_last);
      cmp("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  smf_in_if  in_if ();
  smf_cfg_if cfg_if ();
  smf_out_if out_if ();

  smf_track_event_parser u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  track_scoreboard sb = new();

  bit [7:0]    chunk_q[$];
  int unsigned src_idle_pct;
  int unsigned rcv_idle_pct;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned items_sent;
  int unsigned tracks;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.cmd = 1'b0;
    in_if.chunk_byte = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.track_length = 32'd0;
    out_if.ready = 1'b0;
    src_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    items_sent = 0;
    tracks = 0;
  end

  always #5 clk = ~clk;

  // sink side: random back-pressure, or a long hold-off when asked for
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : capture
    result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind = out_if.kind;
      got.abs_tick = out_if.abs_tick;
      got.event_status = out_if.event_status;
      got.meta_kind = out_if.meta_kind;
      got.payload_length = out_if.payload_length;
      got.param_first = out_if.param_first;
      got.param_second = out_if.param_second;
      got.payload_byte = out_if.payload_byte;
      got.event_last = out_if.event_last;
      got.error_code = out_if.error_code;
      sb.check_result(got);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  // all driving tasks start and end just after a falling edge
  task automatic send_byte(bit cmd, bit [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      in_if.cmd = 1'($urandom);
      in_if.chunk_byte = 8'($urandom);
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.cmd = cmd;
    in_if.chunk_byte = b;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(cmd, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_length(bit [31:0] v);
    cfg_if.valid = 1'b1;
    cfg_if.track_length = v;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_length(v);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic run_track(bit [31:0] len, bit stall_sink);
    drain();
    write_length(len);
    if (stall_sink) hold_req = 1'b1;
    send_byte(1'b1, 8'($urandom));
    foreach (chunk_q[i]) send_byte(1'b0, chunk_q[i]);
    tracks++;
  endtask

  // pads with 0x80 continuation bytes when nb is longer than the value needs
  function automatic void put_vlq(bit [27:0] v, int unsigned nb);
    int unsigned need;
    int i;
    need = 1;
    while (need < 4 && (v >> (7 * need)) != 0) need++;
    if (nb < need) nb = need;
    for (i = nb - 1; i >= 0; i--) chunk_q.push_back({i != 0, 7'(v >> (7 * i))});
  endfunction

  function automatic bit [27:0] pick_delta(bit heavy);
    int unsigned s;
    s = $urandom_range(9);
    if (heavy && s < 6) return VLQ_TOP;
    case (s)
      0, 1, 2: return 28'd0;
      3, 4, 5: return 28'($urandom_range(127));
      6, 7:    return 28'($urandom);
      default: return VLQ_TOP;
    endcase
  endfunction

  function automatic void build_track(int unsigned n_events, bit heavy);
    bit [7:0]    run;
    bit [7:0]    st;
    int unsigned sel, len, k, j;
    run = 8'h00;
    for (k = 0; k < n_events; k++) begin
      put_vlq(pick_delta(heavy), $urandom_range(1, 4));
      sel = $urandom_range(9);
      if (sel <= 4) begin
        st = {4'($urandom_range(8, 14)), 4'($urandom)};
        if (st == run && $urandom_range(1) == 1) begin
          chunk_q.push_back(8'($urandom_range(127)));
        end else begin
          chunk_q.push_back(st);
          chunk_q.push_back(($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(127)));
        end
        run = st;
        if (st[7:4] != NIBBLE_PROGRAM && st[7:4] != NIBBLE_PRESSURE)
          chunk_q.push_back(8'($urandom_range(127)));
      end else begin
        if (sel <= 7) begin
          chunk_q.push_back(STATUS_META);
          chunk_q.push_back(8'($urandom));
        end else begin
          chunk_q.push_back(($urandom_range(1) == 1) ? STATUS_SYSEX : STATUS_SYSEX_ESC);
        end
        len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        put_vlq(28'(len), $urandom_range(1, 2));
        for (j = 0; j < len; j++) chunk_q.push_back(8'($urandom));
        run = 8'h00;
      end
    end
  endfunction

  task automatic random_track();
    int unsigned size, mode, k;
    bit [31:0]   len;
    bit          heavy;
    chunk_q.delete();
    heavy = ($urandom_range(7) == 0);
    build_track(heavy ? 40 : $urandom_range(1, 8), heavy);
    size = chunk_q.size();
    len = size;
    mode = $urandom_range(19);
    case (mode)
      0, 1: len = $urandom_range(size - 1);
      2:    len = size + $urandom_range(1, 20);
      3:    len = 32'hFFFF_FFFF;
      4, 5: chunk_q[$urandom_range(size - 1)] = 8'($urandom);
      6: begin
        chunk_q.delete();
        for (k = $urandom_range(1, 20); k > 0; k--) chunk_q.push_back(8'($urandom));
        len = $urandom_range(24);
      end
      default: ;
    endcase
    run_track(len, 1'b0);
  endtask

  // one long sysex while the sink holds off, so the result queue fills and the input stalls
  task automatic stall_burst();
    int unsigned j;
    chunk_q.delete();
    put_vlq(28'd0, 1);
    chunk_q.push_back(STATUS_SYSEX);
    put_vlq(28'd40, 1);
    for (j = 0; j < 40; j++) chunk_q.push_back(8'($urandom));
    run_track(chunk_q.size(), 1'b1);
  endtask

  initial begin : stimulus
    int unsigned regime, goal;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ignored while finished, then restart with the reset length of zero
    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, 8'h00);
    // overlong delta wins over running out of chunk
    chunk_q = '{8'h80, 8'h80, 8'h80, 8'h80};
    run_track(32'd4, 1'b0);
    // data byte with no running status
    chunk_q = '{8'h00, 8'h45};
    run_track(32'd3, 1'b0);
    // system status that is not allowed in a track
    chunk_q = '{8'h00, 8'hF3};
    run_track(32'd3, 1'b0);
    // note-on status too close to the end, then a byte after the end
    chunk_q = '{8'h00, 8'h90};
    run_track(32'd2, 1'b0);
    send_byte(1'b0, 8'h12);
    // chunk ends on a delta
    chunk_q = '{8'h00, 8'hC5, 8'h10, 8'h05};
    run_track(32'd4, 1'b0);
    // largest declared meta length under the largest track length
    chunk_q = '{8'h00, STATUS_META, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hAA};
    run_track(32'hFFFF_FFFF, 1'b0);
    // length cut below the bytes already taken
    chunk_q = '{8'h00, 8'h90};
    run_track(32'd10, 1'b0);
    drain();
    write_length(32'd1);
    send_byte(1'b0, 8'h3C);

    for (regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          src_idle_pct = 15;
          rcv_idle_pct = 65;
        end
        1: begin
          src_idle_pct = 65;
          rcv_idle_pct = 15;
        end
        default: begin
          src_idle_pct = 0;
          rcv_idle_pct = 0;
          stall_burst();
        end
      endcase
      goal = items_sent + ITEMS_PER_REGIME;
      while (items_sent < goal) random_track();
    end

    drain();
    repeat (20) @(negedge clk);
    $display("%0d byte transfers over %0d tracks; %0d results checked", items_sent, tracks,
             sb.checked);
    $display("headers %0d, payload bytes %0d, track ends %0d, error ends %0d",
             sb.n_header, sb.n_payload, sb.n_end, sb.n_error);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: smf_track_event_parser.f
+incdir+rtl
rtl/smf_pkg.sv
rtl/smf_in_if.sv
rtl/smf_cfg_if.sv
rtl/smf_out_if.sv
rtl/smf_front.sv
rtl/smf_queue.sv
rtl/smf_back.sv
rtl/smf_track_event_parser.sv
verif/testbench.sv
